>>> hdl/hkmo_pkg.sv
`default_nettype none
package hkmo_pkg;
  typedef enum logic [1:0] {
    FN_RECORD = 2'd0,
    FN_LOAD   = 2'd1,
    FN_CLEAR  = 2'd2,
    FN_READ   = 2'd3
  } func_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_CLR,
    ST_REC_RD,
    ST_REC_WAIT,
    ST_REC_WR,
    ST_KRD_WAIT,
    ST_KRD_OUT,
    ST_FIX_RD,
    ST_FIX_WAIT,
    ST_FIX_HW,
    ST_FIX_WR,
    ST_SEL_INIT,
    ST_SEL_RD,
    ST_SEL_WAIT,
    ST_SEL_CMP,
    ST_SEL_EMIT
  } state_t;

  localparam logic [31:0] SCORE_LIMIT = 32'((64'd1 << 31) - 64'd24);
endpackage
`default_nettype wire

>>> hdl/history_killer_move_orderer_top.sv
// History / killer move-ordering store.
// Input channel (in_valid/in_stall) carries one item: record, load, clear or read.
// Output channel (out_valid/out_stall) carries results from a registered output stage.
// One item is processed at a time; in_stall is high while the sequencer is busy.
// Record: read-modify-write of the history memory and the killer memory.
// Read killers: one result with zero move fields, sent once the output is free.
// Clear: walks the history memory one entry per cycle, plus the killer memory in
// parallel; clear is also run after reset before any item is accepted.
// Non-final load: stores the move only. Final load: patches scores from history (those below
// SCORE_LIMIT), then a selection pass emits N results, highest score first, ties in
// load order. Each pass reads the single-port move buffer one entry at a time.
// A stalled result holds the output register and the sequencer waits on it.
// Reset (rst, synchronous) clears the move count and starts the clearing pass.
`default_nettype none
module history_killer_move_orderer_top
  import hkmo_pkg::*;
#(
  parameter int MAX_ROOT_MOVES = 64,
  parameter int NUM_PLIES = 256,
  parameter int NUM_SQUARES = 256
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  func,
  input  wire logic [7:0]  src_square,
  input  wire logic [7:0]  dst_square,
  input  wire logic [31:0] move_score,
  input  wire logic [7:0]  ply,
  input  wire logic [5:0]  depth,
  input  wire logic        final_move,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [7:0]       out_src,
  output logic [7:0]       out_dst,
  output logic [31:0]      out_score,
  output logic             out_last,
  output logic [7:0]       killer_a_src,
  output logic [7:0]       killer_a_dst,
  output logic [7:0]       killer_b_src,
  output logic [7:0]       killer_b_dst
);
  localparam int SQW = $clog2(NUM_SQUARES);
  localparam int HW = 2 * SQW;
  localparam int HD = NUM_SQUARES * NUM_SQUARES;
  localparam int PW = $clog2(NUM_PLIES);
  localparam int MW = $clog2(MAX_ROOT_MOVES);
  localparam int CW = MW + 1;

  state_t state, state_next;

  // memories
  logic [31:0] hist_mem [HD];
  logic [31:0] kill_mem [NUM_PLIES];
  logic [47:0] buf_mem [MAX_ROOT_MOVES];
  logic [31:0] hist_rd;
  logic [31:0] kill_rd;
  logic [47:0] buf_rd;
  logic        hist_we, kill_we, buf_we;
  logic [HW-1:0] hist_addr;
  logic [PW-1:0] kill_addr;
  logic [MW-1:0] buf_addr;
  logic [31:0] hist_wd, kill_wd;
  logic [47:0] buf_wd;

  always_ff @(posedge clk) begin
    if (hist_we) hist_mem[hist_addr] <= hist_wd;
    hist_rd <= hist_mem[hist_addr];
  end
  always_ff @(posedge clk) begin
    if (kill_we) kill_mem[kill_addr] <= kill_wd;
    kill_rd <= kill_mem[kill_addr];
  end
  always_ff @(posedge clk) begin
    if (buf_we) buf_mem[buf_addr] <= buf_wd;
    buf_rd <= buf_mem[buf_addr];
  end

  // item registers
  logic [SQW-1:0] r_src, r_dst;
  logic [PW-1:0]  r_ply;
  logic [11:0]    r_add;
  logic [CW-1:0]  count;
  logic [HW:0]    clr_idx;
  logic [MW-1:0]  idx;      // walk index
  logic [MW-1:0]  best_idx;
  logic [31:0]    best_score;
  logic           best_ok;
  logic [MAX_ROOT_MOVES-1:0] taken;
  logic [CW-1:0]  emitted;
  logic [47:0]    fix_entry;
  logic [7:0]     best_src, best_dst;

  logic in_acc, out_acc, out_load;
  assign in_acc  = in_valid && !in_stall;
  assign out_acc = out_valid && !out_stall;
  assign in_stall = (state != ST_IDLE);
  assign out_load = (state == ST_KRD_OUT || state == ST_SEL_EMIT) &&
                    (!out_valid || out_acc);

  logic [32:0] hsum;
  assign hsum = {1'b0, hist_rd} + {21'd0, r_add};

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (in_acc) begin
        unique case (func_t'(func))
          FN_RECORD: state_next = ST_REC_RD;
          FN_CLEAR:  state_next = ST_CLR;
          FN_READ:   state_next = ST_KRD_WAIT;
          FN_LOAD:   state_next = final_move ? ST_FIX_RD : ST_IDLE;
          default:   state_next = ST_IDLE;
        endcase
      end
      ST_CLR: if (clr_idx == (HW+1)'(HD - 1)) state_next = ST_IDLE;
      ST_REC_RD:   state_next = ST_REC_WAIT;
      ST_REC_WAIT: state_next = ST_REC_WR;
      ST_REC_WR:   state_next = ST_IDLE;
      ST_KRD_WAIT: state_next = ST_KRD_OUT;
      ST_KRD_OUT:  if (!out_valid || out_acc) state_next = ST_IDLE;
      ST_FIX_RD:   state_next = ST_FIX_WAIT;
      ST_FIX_WAIT: state_next = ST_FIX_HW;
      ST_FIX_HW:   state_next = ST_FIX_WR;
      ST_FIX_WR:
        if (CW'(idx) + CW'(1) >= count) state_next = ST_SEL_INIT;
        else state_next = ST_FIX_RD;
      ST_SEL_INIT: state_next = ST_SEL_RD;
      ST_SEL_RD:   state_next = ST_SEL_WAIT;
      ST_SEL_WAIT: state_next = ST_SEL_CMP;
      ST_SEL_CMP:
        if (CW'(idx) + CW'(1) >= count) state_next = ST_SEL_EMIT;
        else state_next = ST_SEL_RD;
      ST_SEL_EMIT:
        if (!out_valid || out_acc) begin
          if (emitted + CW'(1) >= count) state_next = ST_IDLE;
          else state_next = ST_SEL_INIT;
        end
      default: state_next = ST_IDLE;
    endcase
  end

  // memory control
  always_comb begin
    hist_we = 1'b0; kill_we = 1'b0; buf_we = 1'b0;
    hist_addr = {r_src, r_dst};
    kill_addr = r_ply;
    buf_addr = idx;
    hist_wd = '0; kill_wd = '0; buf_wd = '0;
    unique case (state)
      ST_IDLE: begin
        kill_addr = PW'(ply);
        buf_addr = count[MW-1:0];
        buf_wd = {8'(src_square[SQW-1:0]), 8'(dst_square[SQW-1:0]), move_score};
        buf_we = in_acc && func_t'(func) == FN_LOAD &&
                 count < CW'(MAX_ROOT_MOVES);
      end
      ST_CLR: begin
        hist_addr = clr_idx[HW-1:0];
        hist_we = 1'b1;
        kill_addr = clr_idx[PW-1:0];
        kill_we = clr_idx < (HW+1)'(NUM_PLIES);
      end
      ST_REC_WR: begin
        hist_we = 1'b1;
        hist_wd = hsum[32] ? 32'hFFFF_FFFF : hsum[31:0];
        kill_we = kill_rd[15:0] != {8'(r_dst), 8'(r_src)};
        kill_wd = {kill_rd[15:0], 8'(r_dst), 8'(r_src)};
      end
      ST_FIX_HW: hist_addr = {fix_entry[40+SQW-1:40], fix_entry[32+SQW-1:32]};
      ST_FIX_WR: begin
        buf_we = fix_entry[31:0] < SCORE_LIMIT;
        buf_wd = {fix_entry[47:32], hist_rd};
      end
      ST_SEL_EMIT: buf_addr = best_idx;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLR;
      count <= '0;
      clr_idx <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (out_load) out_valid <= 1'b1;
      else if (out_acc) out_valid <= 1'b0;
      unique case (state)
        ST_IDLE: if (in_acc) begin
          r_src <= src_square[SQW-1:0];
          r_dst <= dst_square[SQW-1:0];
          r_ply <= ply[PW-1:0];
          r_add <= 12'(depth) * 12'(depth);
          clr_idx <= '0;
          idx <= '0;
          taken <= '0;
          emitted <= '0;
          if (buf_we) count <= count + CW'(1);
        end
        ST_CLR: clr_idx <= clr_idx + (HW+1)'(1);
        ST_KRD_OUT: if (!out_valid || out_acc) begin
          out_src <= '0; out_dst <= '0; out_score <= '0; out_last <= 1'b0;
          killer_a_src <= kill_rd[7:0];
          killer_a_dst <= kill_rd[15:8];
          killer_b_src <= kill_rd[23:16];
          killer_b_dst <= kill_rd[31:24];
        end
        ST_FIX_WAIT: fix_entry <= buf_rd;
        ST_FIX_WR: idx <= idx + MW'(1);
        ST_SEL_INIT: begin
          idx <= '0;
          best_ok <= 1'b0;
        end
        ST_SEL_CMP: begin
          // strict greater keeps earliest load among equal scores
          if (!taken[idx] && (!best_ok || buf_rd[31:0] > best_score)) begin
            best_ok <= 1'b1;
            best_idx <= idx;
            best_score <= buf_rd[31:0];
          end
          idx <= idx + MW'(1);
        end
        ST_SEL_EMIT: if (!out_valid || out_acc) begin
          out_src <= best_src;
          out_dst <= best_dst;
          out_score <= best_score;
          out_last <= (emitted + CW'(1) >= count);
          killer_a_src <= '0; killer_a_dst <= '0;
          killer_b_src <= '0; killer_b_dst <= '0;
          taken[best_idx] <= 1'b1;
          emitted <= emitted + CW'(1);
          if (emitted + CW'(1) >= count) count <= '0;
        end
        default: ;
      endcase
    end
  end

  // best move squares captured during the compare pass
  always_ff @(posedge clk) begin
    if (state == ST_SEL_CMP && !taken[idx] &&
        (!best_ok || buf_rd[31:0] > best_score)) begin
      best_src <= buf_rd[47:40];
      best_dst <= buf_rd[39:32];
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    in_acc |=> !(state == ST_IDLE && $past(func) == FN_CLEAR))
    else $error("clear item did not start clearing pass");
  assert property (@(posedge clk) disable iff (rst)
    count <= CW'(MAX_ROOT_MOVES))
    else $error("move count overflow");
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> out_valid)
    else $error("pending result lost");
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_SEL_EMIT && state_next == ST_IDLE) |=> count == '0)
    else $error("count not reset after sorted run");
endmodule
`default_nettype wire
